FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the splitter top level. They expect clk and
// arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("splitter assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("splitter assertion failed");

`endif

FILE: rtl/pels_pkg.sv
// ----------------------------------------------------------------------------
// pels_pkg
// Shared widths, register indexes and data types of the edge line splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pels_pkg;

	localparam int COORD_BITS   = 16;
	localparam int ON_LINE_BAND = 2;

	localparam int CW      = COORD_BITS;       // coordinate width
	localparam int DW      = CW + 1;           // direction width
	localparam int DFW     = CW + 1;           // difference of two coordinates
	localparam int MW      = DW + DFW;         // one product
	localparam int SW      = MW + 1;           // sum of two products
	localparam int SPL     = (SW + 1) / 2;     // low part of the split square
	localparam int SHW     = SW - SPL;         // high part of the split square
	localparam int QW      = 2 * SW;           // square of a cross product
	localparam int NW      = DFW + SW + 1;     // intersection numerator
	localparam int BAND_SQ = ON_LINE_BAND * ON_LINE_BAND;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = DW;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		SIDE_ON,
		SIDE_LEFT,
		SIDE_RIGHT
	} side_t;

	// Per-edge data that rides along with the arithmetic.
	typedef struct packed {
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		side_t                ss;
		side_t                es;
	} tag_t;

	typedef struct packed {
		logic signed [NW-1:0] num_x;
		logic signed [NW-1:0] num_y;
		logic signed [SW-1:0] det;
		tag_t                 tag;
	} front_t;

	typedef struct packed {
		logic signed [CW-1:0] ix;
		logic signed [CW-1:0] iy;
		logic                 pe;
		tag_t                 tag;
	} div_res_t;

endpackage

`default_nettype wire

FILE: rtl/pels_front.sv
// ----------------------------------------------------------------------------
// pels_front
// Five-stage arithmetic front end: classifies both endpoints of an edge and
// forms the intersection numerators and determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module pels_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic signed [pels_pkg::CW-1:0] start_x,
	input  wire logic signed [pels_pkg::CW-1:0] start_y,
	input  wire logic signed [pels_pkg::CW-1:0] end_x,
	input  wire logic signed [pels_pkg::CW-1:0] end_y,
	input  wire logic signed [pels_pkg::CW-1:0] ox,
	input  wire logic signed [pels_pkg::CW-1:0] oy,
	input  wire logic signed [pels_pkg::DW-1:0] dx,
	input  wire logic signed [pels_pkg::DW-1:0] dy,
	output logic                                out_valid,
	output pels_pkg::front_t                    out
);
	import pels_pkg::*;

	localparam logic signed [DFW-1:0] BAND_P = DFW'(ON_LINE_BAND);
	localparam logic signed [DFW-1:0] BAND_N = -BAND_P;

	// Classification for splitters along an axis; dy is zero when dx is not.
	function automatic side_t axis_side(input logic signed [DFW-1:0] px,
	                                    input logic signed [DFW-1:0] py,
	                                    input logic signed [DW-1:0]  ddx,
	                                    input logic signed [DW-1:0]  ddy);
		side_t r;
		if (ddx == '0) begin
			if (px > BAND_N && px < BAND_P)
				r = SIDE_ON;
			else if (px[DFW-1])
				r = (!ddy[DW-1] && ddy != '0) ? SIDE_LEFT : SIDE_RIGHT;
			else
				r = ddy[DW-1] ? SIDE_LEFT : SIDE_RIGHT;
		end else begin
			if (py > BAND_N && py < BAND_P)
				r = SIDE_ON;
			else if (py[DFW-1])
				r = ddx[DW-1] ? SIDE_LEFT : SIDE_RIGHT;
			else
				r = (!ddx[DW-1] && ddx != '0) ? SIDE_LEFT : SIDE_RIGHT;
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1: differences and axis classification.
	logic signed [DFW-1:0] dpx0_s1, dpy0_s1, dpx1_s1, dpy1_s1, a2_s1, b2_s1;
	logic signed [CW-1:0]  sx_s1, sy_s1, ex_s1, ey_s1;
	side_t                 ax0_s1, ax1_s1;
	logic                  axis_s1;

	logic signed [DFW-1:0] dpx0, dpy0, dpx1, dpy1;
	always_comb begin
		dpx0 = DFW'(start_x) - DFW'(ox);
		dpy0 = DFW'(start_y) - DFW'(oy);
		dpx1 = DFW'(end_x) - DFW'(ox);
		dpy1 = DFW'(end_y) - DFW'(oy);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dpx0_s1 <= dpx0;
			dpy0_s1 <= dpy0;
			dpx1_s1 <= dpx1;
			dpy1_s1 <= dpy1;
			a2_s1   <= DFW'(end_y) - DFW'(start_y);
			b2_s1   <= DFW'(start_x) - DFW'(end_x);
			sx_s1   <= start_x;
			sy_s1   <= start_y;
			ex_s1   <= end_x;
			ey_s1   <= end_y;
			ax0_s1  <= axis_side(dpx0, dpy0, dx, dy);
			ax1_s1  <= axis_side(dpx1, dpy1, dx, dy);
			axis_s1 <= (dx == '0) || (dy == '0);
		end
	end

	// Stage 2: all the single products.
	logic signed [MW-1:0]  m0a_s2, m0b_s2, m1a_s2, m1b_s2;
	logic signed [MW-1:0]  c2a_s2, c2b_s2, c1a_s2, c1b_s2, deta_s2, detb_s2;
	logic signed [MW-1:0]  dx2_s2, dy2_s2;
	logic signed [DFW-1:0] a2_s2, b2_s2;
	logic signed [CW-1:0]  ex_s2, ey_s2;
	side_t                 ax0_s2, ax1_s2;
	logic                  axis_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			m0a_s2  <= MW'(dpx0_s1 * dy);
			m0b_s2  <= MW'(dpy0_s1 * dx);
			m1a_s2  <= MW'(dpx1_s1 * dy);
			m1b_s2  <= MW'(dpy1_s1 * dx);
			c2a_s2  <= MW'(a2_s1 * sx_s1);
			c2b_s2  <= MW'(b2_s1 * sy_s1);
			c1a_s2  <= MW'(dy * ox);
			c1b_s2  <= MW'(dx * oy);
			deta_s2 <= MW'(dy * b2_s1);
			detb_s2 <= MW'(a2_s1 * dx);
			dx2_s2  <= MW'(dx * dx);
			dy2_s2  <= MW'(dy * dy);
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;
			ax0_s2  <= ax0_s1;
			ax1_s2  <= ax1_s1;
			axis_s2 <= axis_s1;
		end
	end

	// Stage 3: sums of products.
	logic signed [SW-1:0]  s0_s3, s1_s3, c1_s3, c2_s3, det_s3, asum;
	logic signed [QW-1:0]  lim_s3;
	logic signed [DFW-1:0] a2_s3, b2_s3;
	logic signed [CW-1:0]  ex_s3, ey_s3;
	side_t                 ax0_s3, ax1_s3;
	logic                  axis_s3;

	assign asum = SW'(dx2_s2) + SW'(dy2_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			s0_s3   <= SW'(m0a_s2) - SW'(m0b_s2);
			s1_s3   <= SW'(m1a_s2) - SW'(m1b_s2);
			c1_s3   <= SW'(c1a_s2) - SW'(c1b_s2);
			c2_s3   <= SW'(c2a_s2) + SW'(c2b_s2);
			det_s3  <= SW'(deta_s2) + SW'(detb_s2);
			lim_s3  <= QW'(asum) * QW'(BAND_SQ);
			a2_s3   <= a2_s2;
			b2_s3   <= b2_s2;
			ex_s3   <= ex_s2;
			ey_s3   <= ey_s2;
			ax0_s3  <= ax0_s2;
			ax1_s3  <= ax1_s2;
			axis_s3 <= axis_s2;
		end
	end

	// Stage 4: partial products of the squares and the numerator products.
	// A cross product s is split as hi*2^SPL + lo with lo unsigned.
	logic signed [2*SHW-1:0]  hh0_s4, hh1_s4;
	logic signed [SHW+SPL:0]  hl0_s4, hl1_s4;
	logic        [2*SPL-1:0]  ll0_s4, ll1_s4;
	logic signed [NW-1:0]     nxa_s4, nxb_s4, nya_s4, nyb_s4;
	logic signed [QW-1:0]     lim_s4;
	logic signed [SW-1:0]     det_s4;
	logic                     sn0_s4, sn1_s4;
	logic signed [CW-1:0]     ex_s4, ey_s4;
	side_t                    ax0_s4, ax1_s4;
	logic                     axis_s4;

	logic signed [SHW-1:0] hi0, hi1;
	logic        [SPL-1:0] lo0, lo1;
	assign hi0 = s0_s3[SW-1:SPL];
	assign hi1 = s1_s3[SW-1:SPL];
	assign lo0 = s0_s3[SPL-1:0];
	assign lo1 = s1_s3[SPL-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			hh0_s4  <= (2*SHW)'(hi0 * hi0);
			hh1_s4  <= (2*SHW)'(hi1 * hi1);
			hl0_s4  <= (SHW+SPL+1)'(hi0 * $signed({1'b0, lo0}));
			hl1_s4  <= (SHW+SPL+1)'(hi1 * $signed({1'b0, lo1}));
			ll0_s4  <= (2*SPL)'(lo0 * lo0);
			ll1_s4  <= (2*SPL)'(lo1 * lo1);
			nxa_s4  <= NW'(b2_s3 * c1_s3);
			nxb_s4  <= NW'(dx * c2_s3);
			nya_s4  <= NW'(dy * c2_s3);
			nyb_s4  <= NW'(a2_s3 * c1_s3);
			lim_s4  <= lim_s3;
			det_s4  <= det_s3;
			sn0_s4  <= s0_s3[SW-1];
			sn1_s4  <= s1_s3[SW-1];
			ex_s4   <= ex_s3;
			ey_s4   <= ey_s3;
			ax0_s4  <= ax0_s3;
			ax1_s4  <= ax1_s3;
			axis_s4 <= axis_s3;
		end
	end

	// Stage 5: squares against the band limit, final sides and numerators.
	logic signed [QW-1:0] sq0, sq1;
	side_t                g0, g1;
	always_comb begin
		sq0 = (QW'(hh0_s4) <<< (2*SPL)) + (QW'(hl0_s4) <<< (SPL+1))
		      + QW'($signed({1'b0, ll0_s4}));
		sq1 = (QW'(hh1_s4) <<< (2*SPL)) + (QW'(hl1_s4) <<< (SPL+1))
		      + QW'($signed({1'b0, ll1_s4}));
		g0  = (sq0 < lim_s4) ? SIDE_ON : (sn0_s4 ? SIDE_LEFT : SIDE_RIGHT);
		g1  = (sq1 < lim_s4) ? SIDE_ON : (sn1_s4 ? SIDE_LEFT : SIDE_RIGHT);
	end

	front_t res_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5.num_x  <= nxa_s4 + nxb_s4;
			res_s5.num_y  <= nya_s4 - nyb_s4;
			res_s5.det    <= det_s4;
			res_s5.tag.ex <= ex_s4;
			res_s5.tag.ey <= ey_s4;
			res_s5.tag.ss <= axis_s4 ? ax0_s4 : g0;
			res_s5.tag.es <= axis_s4 ? ax1_s4 : g1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;
	assign out       = res_s5;

endmodule

`default_nettype wire

FILE: rtl/pels_div.sv
// ----------------------------------------------------------------------------
// pels_div
// Pipelined restoring divider for both intersection coordinates, one
// quotient bit per stage, with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pels_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire logic         in_valid,
	input  pels_pkg::front_t  in,
	output logic              out_valid,
	output pels_pkg::div_res_t out
);
	import pels_pkg::*;

	typedef struct packed {
		logic [NW-1:0] rem_x;
		logic [NW-1:0] rem_y;
		logic [CW-1:0] q_x;
		logic [CW-1:0] q_y;
		logic [SW-1:0] d;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic          pe;
		tag_t          tag;
	} dstage_t;

	// Stage 1: magnitudes and result signs.
	logic          v_s1;
	logic [NW-1:0] mag_x_s1, mag_y_s1;
	logic [SW-1:0] d_s1;
	logic          neg_x_s1, neg_y_s1, pe_s1;
	tag_t          tag_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s1 <= in.num_x[NW-1] ? NW'(-in.num_x) : NW'(in.num_x);
			mag_y_s1 <= in.num_y[NW-1] ? NW'(-in.num_y) : NW'(in.num_y);
			d_s1     <= in.det[SW-1] ? SW'(-in.det) : SW'(in.det);
			neg_x_s1 <= in.num_x[NW-1] ^ in.det[SW-1];
			neg_y_s1 <= in.num_y[NW-1] ^ in.det[SW-1];
			pe_s1    <= (in.det == '0);
			tag_s1   <= in.tag;
		end
	end

	// Stage 2: a quotient that needs more than CW bits saturates anyway.
	logic    v_st [0:CW];
	dstage_t st_s [0:CW];
	logic [NW-1:0] dtop;
	assign dtop = NW'(d_s1) << CW;

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0].rem_x <= mag_x_s1;
			st_s[0].rem_y <= mag_y_s1;
			st_s[0].q_x   <= '0;
			st_s[0].q_y   <= '0;
			st_s[0].d     <= d_s1;
			st_s[0].neg_x <= neg_x_s1;
			st_s[0].neg_y <= neg_y_s1;
			st_s[0].ovf_x <= (mag_x_s1 >= dtop);
			st_s[0].ovf_y <= (mag_y_s1 >= dtop);
			st_s[0].pe    <= pe_s1;
			st_s[0].tag   <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_st[0] <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			v_st[0] <= v_s1;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < CW; k++) begin : g_step
		localparam int SH = CW - 1 - k;
		logic [NW-1:0] dsh;
		logic [NW:0]   tx, ty;
		dstage_t       nxt;

		always_comb begin
			dsh       = NW'(st_s[k].d) << SH;
			tx        = {1'b0, st_s[k].rem_x} - {1'b0, dsh};
			ty        = {1'b0, st_s[k].rem_y} - {1'b0, dsh};
			nxt       = st_s[k];
			nxt.rem_x = tx[NW] ? st_s[k].rem_x : tx[NW-1:0];
			nxt.rem_y = ty[NW] ? st_s[k].rem_y : ty[NW-1:0];
			nxt.q_x   = {st_s[k].q_x[CW-2:0], !tx[NW]};
			nxt.q_y   = {st_s[k].q_y[CW-2:0], !ty[NW]};
		end

		always_ff @(posedge clk) begin
			if (adv)
				st_s[k+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_st[k+1] <= 1'b0;
			else if (adv)
				v_st[k+1] <= v_st[k];
		end
	end

	// Final stage: saturate, apply sign, zero on a parallel edge.
	logic [CW-1:0] lim_x, lim_y, mx, my;
	dstage_t       fin;
	assign fin = st_s[CW];

	always_comb begin
		lim_x = fin.neg_x ? CW'(1) << (CW - 1) : (CW'(1) << (CW - 1)) - CW'(1);
		lim_y = fin.neg_y ? CW'(1) << (CW - 1) : (CW'(1) << (CW - 1)) - CW'(1);
		mx    = (fin.ovf_x || fin.q_x > lim_x) ? lim_x : fin.q_x;
		my    = (fin.ovf_y || fin.q_y > lim_y) ? lim_y : fin.q_y;
	end

	div_res_t res_q;
	logic     v_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.ix  <= fin.pe ? '0 : $signed(fin.neg_x ? -mx : mx);
			res_q.iy  <= fin.pe ? '0 : $signed(fin.neg_y ? -my : my);
			res_q.pe  <= fin.pe;
			res_q.tag <= fin.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (adv)
			v_q <= v_st[CW];
	end

	assign out_valid = v_q;
	assign out       = res_q;

endmodule

`default_nettype wire

FILE: rtl/pels_out.sv
// ----------------------------------------------------------------------------
// pels_out
// Output register that turns one finished edge into one or two result
// requests and holds the pipeline when it cannot take another edge.
// ----------------------------------------------------------------------------
`default_nettype none

module pels_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          res_valid,
	input  pels_pkg::div_res_t                 res,
	input  wire logic                          out_stall,
	output logic                               adv,
	output logic                               out_valid,
	output logic signed [pels_pkg::CW-1:0]     point_x,
	output logic signed [pels_pkg::CW-1:0]     point_y,
	output logic                               to_left,
	output logic                               to_right,
	output logic                               parallel_error,
	output logic                               last
);
	import pels_pkg::*;

	div_res_t hold_q;
	logic     valid_q, phase_q;
	logic     two, first, take, done, free;

	always_comb begin
		two   = (hold_q.tag.es != SIDE_ON) && (hold_q.tag.ss != hold_q.tag.es);
		first = two && !phase_q;
		take  = valid_q && !out_stall;
		done  = take && !first;
		free  = !valid_q || done;
		adv   = !res_valid || free;
	end

	always_ff @(posedge clk) begin
		if (res_valid && free)
			hold_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (res_valid && free) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			phase_q <= 1'b1;
		end
	end

	assign out_valid      = valid_q;
	assign point_x        = first ? hold_q.ix : hold_q.tag.ex;
	assign point_y        = first ? hold_q.iy : hold_q.tag.ey;
	assign to_left        = first || (hold_q.tag.es != SIDE_RIGHT);
	assign to_right       = first || (hold_q.tag.es != SIDE_LEFT);
	assign parallel_error = first && hold_q.pe;
	assign last           = !first;

endmodule

`default_nettype wire

FILE: rtl/polygon_edge_line_splitter.sv
// ----------------------------------------------------------------------------
// polygon_edge_line_splitter
// Splits a polygon, given one edge per request, by a directed splitter line.
// ----------------------------------------------------------------------------
// The block takes one polygon edge per input request and returns the points
// that the edge adds to the left and right halves of the polygon, split by
// the line through origin (origin_x, origin_y) with direction (dir_x, dir_y).
// An edge whose end lies on the line, or whose ends lie on the same side,
// gives one result request; any other edge gives two: first
// the intersection point for both lists (with parallel_error set and the
// point zero when the lines are parallel), then the end point. The pipeline
// accepts a new edge every cycle and the output port returns one result per
// cycle while no stall holds them; a crossing edge can hold the pipeline
// while its second result waits. Each edge passes the classification and
// product stages, the bit-per-stage divider and the output register. While
// results are stalled at the output and a finished edge waits behind them,
// the whole pipeline holds. Configuration registers are written through
// cfg_we, cfg_index and cfg_data and must only change while no edges are in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module polygon_edge_line_splitter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pels_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pels_pkg::CFG_DW-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [pels_pkg::CW-1:0]     start_x,
	input  wire logic signed [pels_pkg::CW-1:0]     start_y,
	input  wire logic signed [pels_pkg::CW-1:0]     end_x,
	input  wire logic signed [pels_pkg::CW-1:0]     end_y,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [pels_pkg::CW-1:0]          point_x,
	output logic signed [pels_pkg::CW-1:0]          point_y,
	output logic                                    to_left,
	output logic                                    to_right,
	output logic                                    parallel_error,
	output logic                                    last
);
	import pels_pkg::*;

	// Splitter registers. The reset line points along +x through the origin.
	logic signed [CW-1:0] origin_x_q, origin_y_q;
	logic signed [DW-1:0] dir_x_q, dir_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			dir_x_q    <= DW'(1);
			dir_y_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data[CW-1:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[CW-1:0];
				REG_DIR_X:    dir_x_q    <= cfg_data;
				REG_DIR_Y:    dir_y_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A single advance signal moves every pipeline stage together; it drops
	// only when the output register is full and cannot free itself.
	logic     adv;
	logic     fr_valid, dv_valid;
	front_t   fr;
	div_res_t dv;

	assign in_stall = !adv;

	pels_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.ox       (origin_x_q),
		.oy       (origin_y_q),
		.dx       (dir_x_q),
		.dy       (dir_y_q),
		.out_valid(fr_valid),
		.out      (fr)
	);

	pels_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (fr_valid),
		.in       (fr),
		.out_valid(dv_valid),
		.out      (dv)
	);

	pels_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (dv_valid),
		.res           (dv),
		.out_stall     (out_stall),
		.adv           (adv),
		.out_valid     (out_valid),
		.point_x       (point_x),
		.point_y       (point_y),
		.to_left       (to_left),
		.to_right      (to_right),
		.parallel_error(parallel_error),
		.last          (last)
	);

	// The input is held back only when a result is waiting at the output.
	`ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid)
	// A parallel flag only comes with the intersection, sent to both lists.
	`ASSERT_IMPL(a_pe_on_first, out_valid && parallel_error, to_left && to_right && !last)
	// Once the intersection is taken, the end point of that edge follows.
	`ASSERT_NEXT(a_second_follows, out_valid && !out_stall && !last, out_valid && last)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polygon edge line splitter.
// ----------------------------------------------------------------------------
// Edges are pushed through the request port with random gaps, results are
// drained with random stalls, and every result is compared with the point
// list that a behavioral predictor of the splitter expects. The splitter
// line is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import pels_pkg::*;

	typedef struct {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic                 lft;
		logic                 rgt;
		logic                 pe;
		logic                 lst;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey;
		logic                 has_exp;
		logic                 exp_l, exp_r, exp_pe;
		logic signed [CW-1:0] exp_x, exp_y;
	} row_t;

	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_MAX = 2000;
	localparam int N_RANDOM     = 1950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ORIGIN_X;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] point_x, point_y;
	logic to_left, to_right, parallel_error, last;

	// The predictor keeps its own copy of the splitter line.
	longint line_ox = 0, line_oy = 0, line_dx = 1, line_dy = 0;

	point_t expected_points[$];
	int mismatches = 0;
	int results_seen = 0;
	int crossings_seen = 0;
	int parallels_seen = 0;
	int edges_sent = 0;
	int idle_cycles = 0;
	int out_wait = 0;
	bit stim_done = 1'b0;

	polygon_edge_line_splitter uut (.*);

	always #4 clk = ~clk;

	// Sides are encoded with the package enum: left, right or on the line.
	function automatic side_t side_of(longint px, longint py);
		longint s;
		longint unsigned a;
		logic [127:0] s2;
		if (line_dx == 0) begin
			if (px > line_ox - ON_LINE_BAND && px < line_ox + ON_LINE_BAND) return SIDE_ON;
			if (px < line_ox) return (line_dy > 0) ? SIDE_LEFT : SIDE_RIGHT;
			return (line_dy < 0) ? SIDE_LEFT : SIDE_RIGHT;
		end
		if (line_dy == 0) begin
			if (py > line_oy - ON_LINE_BAND && py < line_oy + ON_LINE_BAND) return SIDE_ON;
			if (py < line_oy) return (line_dx < 0) ? SIDE_LEFT : SIDE_RIGHT;
			return (line_dx > 0) ? SIDE_LEFT : SIDE_RIGHT;
		end
		s = (px - line_ox) * line_dy - (py - line_oy) * line_dx;
		a = line_dx * line_dx + line_dy * line_dy;
		s2 = 128'(s < 0 ? -s : s) * 128'(s < 0 ? -s : s);
		if (s2 < 128'(a) * BAND_SQ) return SIDE_ON;
		return (s > 0) ? SIDE_RIGHT : SIDE_LEFT;
	endfunction

	// Quotient truncated toward zero, saturated to the coordinate range.
	function automatic logic signed [CW-1:0] quot_sat(logic signed [127:0] num, longint den);
		logic signed [127:0] q;
		q = num / 128'(den);
		if (q > 128'sd32767) return 16'sh7fff;
		if (q < -128'sd32768) return 16'sh8000;
		return q[CW-1:0];
	endfunction

	task automatic predict_points(input logic signed [CW-1:0] sx, sy, ex, ey);
		side_t ss, es;
		longint a2, b2, c1, c2, det;
		logic signed [127:0] nx, ny;
		point_t p;
		ss = side_of(sx, sy);
		es = side_of(ex, ey);
		p = '{ex, ey, 1'b1, 1'b1, 1'b0, 1'b1};
		if (es == SIDE_ON) begin
			expected_points.push_back(p);
			return;
		end
		if (ss == es) begin
			p.lft = (es == SIDE_LEFT);
			p.rgt = (es == SIDE_RIGHT);
			expected_points.push_back(p);
			return;
		end
		a2 = longint'(ey) - sy;
		b2 = longint'(sx) - ex;
		c1 = line_dy * line_ox - line_dx * line_oy;
		c2 = a2 * sx + b2 * sy;
		det = line_dy * b2 + a2 * line_dx;
		p = '{'0, '0, 1'b1, 1'b1, 1'b0, 1'b0};
		if (det == 0) begin
			p.pe = 1'b1;
		end else begin
			nx = 128'(b2) * 128'(c1) + 128'(line_dx) * 128'(c2);
			ny = 128'(line_dy) * 128'(c2) - 128'(a2) * 128'(c1);
			p.px = quot_sat(nx, det);
			p.py = quot_sat(ny, det);
		end
		expected_points.push_back(p);
		p = '{ex, ey, es == SIDE_LEFT, es == SIDE_RIGHT, 1'b0, 1'b1};
		expected_points.push_back(p);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X: line_ox = longint'(signed'(CW'(val)));
			REG_ORIGIN_Y: line_oy = longint'(signed'(CW'(val)));
			REG_DIR_X:    line_dx = longint'(signed'(DW'(val)));
			default:      line_dy = longint'(signed'(DW'(val)));
		endcase
	endtask

	task automatic set_line(input longint ox, oy, dx, dy);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
	endtask

	// Wait for every expected point, then for the pipeline latency, since
	// nothing here can be in flight without an expectation.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One edge request. A point given by the table row replaces the first
	// predicted point so that the typed value is checked; a note shows any
	// difference. The valid line stays up after acceptance so that back-to-back
	// edges need no gap; it drops only when a gap is drawn or the sender pauses.
	task automatic send_edge(input row_t r);
		int gap;
		int n0;
		gap = $urandom_range(0, 4);
		if (($urandom & 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		n0 = expected_points.size();
		predict_points(r.sx, r.sy, r.ex, r.ey);
		if (r.has_exp) begin
			point_t p;
			p = expected_points[n0];
			if (p.px !== r.exp_x || p.py !== r.exp_y || p.lft !== r.exp_l ||
			    p.rgt !== r.exp_r || p.pe !== r.exp_pe)
				$display("Note: typed row and prediction differ for edge %0d", edges_sent);
			expected_points[n0].px = r.exp_x;
			expected_points[n0].py = r.exp_y;
			expected_points[n0].lft = r.exp_l;
			expected_points[n0].rgt = r.exp_r;
			expected_points[n0].pe = r.exp_pe;
		end
		in_valid <= 1'b1;
		start_x <= r.sx;
		start_y <= r.sy;
		end_x <= r.ex;
		end_y <= r.ey;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		edges_sent++;
	endtask

	function automatic row_t mk(int sx, sy, ex, ey);
		row_t r;
		r = '{CW'(sx), CW'(sy), CW'(ex), CW'(ey), 1'b0, 1'b0, 1'b0, 1'b0, '0, '0};
		return r;
	endfunction

	function automatic row_t mk_exp(int sx, sy, ex, ey, logic l, rr, pe, int x, y);
		row_t r;
		r = mk(sx, sy, ex, ey);
		r.has_exp = 1'b1;
		r.exp_l = l;
		r.exp_r = rr;
		r.exp_pe = pe;
		r.exp_x = CW'(x);
		r.exp_y = CW'(y);
		return r;
	endfunction

	function automatic int rcoord(int span);
		if (($urandom & 7) == 0) return int'(signed'(16'($urandom)));
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// Result side: random stalls, then comparison against the oldest point.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				point_t p;
				results_seen++;
				if (expected_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected point (%0d,%0d)", point_x, point_y);
				end else begin
					p = expected_points.pop_front();
					if (point_x !== p.px || point_y !== p.py || to_left !== p.lft ||
					    to_right !== p.rgt || parallel_error !== p.pe || last !== p.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: exp (%0d,%0d) l%b r%b pe%b last%b got (%0d,%0d) l%b r%b pe%b last%b",
								p.px, p.py, p.lft, p.rgt, p.pe, p.lst, point_x, point_y,
								to_left, to_right, parallel_error, last);
					end
					if (!p.lst) crossings_seen++;
					if (p.pe) parallels_seen++;
				end
				// Each result draws how many cycles the drain waits before the next.
				out_wait = $urandom_range(0, 4);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait != 0);
		end
	end

	// Watchdog: too many cycles without any accepted request ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_MAX && !stim_done) begin
			$display("Watchdog expired with %0d points outstanding", expected_points.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[$];
		row_t r;
		int k;
		int phase;
		longint dx, dy;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed edges against the reset line, the x axis pointing right.
		// Above the band is left, below is right, |y| < 2 is on the line.
		dir_rows.push_back(mk_exp(0, 5, 10, 1, 1, 1, 0, 10, 1));
		dir_rows.push_back(mk_exp(0, 5, 10, 7, 1, 0, 0, 10, 7));
		dir_rows.push_back(mk_exp(0, -5, 10, -7, 0, 1, 0, 10, -7));
		dir_rows.push_back(mk_exp(0, 4, 0, -4, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk_exp(0, -4, 8, 4, 1, 1, 0, 4, 0));
		dir_rows.push_back(mk_exp(-32768, -32768, 32767, 32767, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk_exp(32767, 32767, -32768, -32768, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk_exp(5, 1, 5, -2, 1, 1, 0, 5, 0));
		dir_rows.push_back(mk_exp(5, 0, 5, 2, 1, 1, 0, 5, 0));
		dir_rows.push_back(mk(-32768, 32767, 32767, -32768));
		dir_rows.push_back(mk(32767, -32768, -32768, 32767));
		dir_rows.push_back(mk(-1, -1, 0, 0));
		foreach (dir_rows[i]) send_edge(dir_rows[i]);
		wait_idle();

		// Zero direction, then a vertical line pointing down: parallel lines cannot
		// cross the line, but the zero direction gives a parallel error on a start on the band.
		set_line(0, 0, 0, 0);
		send_edge(mk_exp(1, 0, 9, 9, 1, 1, 1, 0, 0));
		send_edge(mk(-9, 3, 9, 3));
		send_edge(mk(9, 3, 20, 30));
		wait_idle();
		set_line(100, -200, 0, -65535);
		send_edge(mk(-32768, 0, 32767, 0));
		send_edge(mk(32767, 5, -32768, 9));
		send_edge(mk(101, 5, 500, 9));
		wait_idle();
		// Extreme diagonal line with origin in a corner.
		set_line(-32768, 32767, 65535, -65535);
		send_edge(mk(-32768, -32768, 32767, 32767));
		send_edge(mk(32767, 32767, -32768, -32768));
		send_edge(mk(0, 0, 0, 1));
		wait_idle();
		set_line(32767, -32768, -65536, 65535);
		send_edge(mk(-32768, -32768, 32767, 32767));
		send_edge(mk(0, 0, 5, 5));
		wait_idle();

		// Random phases: each picks a new line, sometimes axis aligned,
		// sometimes a zero or extreme direction.
		k = 0;
		phase = 0;
		while (k < N_RANDOM) begin
			case ($urandom_range(0, 5))
				0: begin dx = 0; dy = $urandom_range(0, 1) ? 1 : -3; end
				1: begin dx = $urandom_range(0, 1) ? -7 : 2; dy = 0; end
				2: begin dx = $urandom_range(0, 1) ? 65535 : -65536; dy = -65535; end
				3: begin dx = 0; dy = 0; end
				default: begin
					dx = $urandom_range(0, 400) - 200;
					dy = $urandom_range(0, 400) - 200;
				end
			endcase
			set_line(rcoord(300), rcoord(300), dx, dy);
			for (int i = 0; i < 150 && k < N_RANDOM; i++) begin
				int span;
				span = ($urandom_range(0, 3) == 0) ? 32767 : 400;
				r = mk(rcoord(span), rcoord(span), rcoord(span), rcoord(span));
				// Some edges run parallel to the line.
				if ($urandom_range(0, 9) == 0) begin
					r.ex = CW'(longint'(r.sx) + dx);
					r.ey = CW'(longint'(r.sy) + dy);
				end
				send_edge(r);
				k++;
				// The sender holds off now and then until the pipe is empty.
				if ($urandom_range(0, 99) == 0) begin
					in_valid <= 1'b0;
					while (expected_points.size() != 0) @(posedge clk);
				end
			end
			wait_idle();
			phase++;
		end

		stim_done = 1'b1;
		$display("Sent %0d edges over %0d random lines; %0d points checked,", edges_sent,
			phase, results_seen);
		$display("%0d crossings and %0d parallel cases among them.", crossings_seen,
			parallels_seen);
		if (mismatches == 0 && expected_points.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d points missing", mismatches,
				expected_points.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
